/* sv/lkvc_pkg.sv */
// Shared types for the LRU key-value cache.
package lkvc_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] value;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic update;
  } cell_ctrl_t;

  localparam logic ACTION_GET = 1'b0;
  localparam logic ACTION_PUT = 1'b1;

endpackage

/* sv/lkvc_cell.sv */
// One slot of the recency-ordered entry chain; position zero is the most recent.
module lkvc_cell #(
  parameter int INDEX = 0,
  parameter int IW    = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  lkvc_pkg::cell_ctrl_t ctrl,
  input  logic [IW-1:0]       limit,
  input  logic [31:0]         req_key,
  input  lkvc_pkg::entry_t    prev,
  output lkvc_pkg::entry_t    entry,
  output logic                match
);

  logic        valid;
  logic [31:0] key;
  logic [31:0] value;
  logic        take;

  // A cell at or in front of the limit takes its upstream neighbor's entry.
  assign take = ctrl.update && (IW'(INDEX) <= limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctrl.capture) begin
        match <= valid && (key == req_key);
      end
      if (take) begin
        valid <= prev.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key   <= prev.key;
      value <= prev.value;
    end
  end

  assign entry = '{valid: valid, key: key, value: value};

endmodule

/* sv/lru_key_value_cache.sv */
// Top level of the LRU key-value cache: request FSM, occupancy and the cell chain.
//
//   channel  dir  handshake         payload
//   cfg      in   cfg_valid/ready   cfg_data = entries_in_use
//   s        in   s_tvalid/tready   tuser = action, tdata = key, value
//   m        out  m_tvalid/tready   tuser = hit, tdata = read_value
//
// Each request passes through the transfer, a compare cycle in which every
// cell registers its key match, and an update cycle in which the chain shifts.
// The update waits while the output register still holds an untaken result.
// Reset clears all valid bits, the occupancy count and sets the capacity to 8.
// Recency is the position in the chain, so no rank values are stored.
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,   // entries_in_use
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,    // key [31:0], value [63:32]
  input  logic        s_tuser,    // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // read_value
  output logic        m_tuser     // hit
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  lkvc_pkg::state_t     state;
  lkvc_pkg::state_t     state_next;
  lkvc_pkg::cell_ctrl_t ctrl;

  logic [3:0]    cap_reg;
  logic [CW-1:0] cap_eff;
  logic [CW-1:0] count;
  logic          req_action;
  logic [31:0]   req_key;
  logic [31:0]   req_value;

  lkvc_pkg::entry_t cell_entry [MAX_ENTRIES];
  lkvc_pkg::entry_t cell_prev  [MAX_ENTRIES];
  lkvc_pkg::entry_t head;
  logic [MAX_ENTRIES-1:0] match_vec;
  logic [MAX_ENTRIES-1:0] valid_vec;

  logic          out_free;
  logic          hit;
  logic [IW-1:0] hit_pos;
  logic [31:0]   hit_value;
  logic          full;
  logic [IW-1:0] limit;
  logic          do_update;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == lkvc_pkg::ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      cap_reg <= cfg_data;
    end
  end

  // A capacity of zero acts as one; values above the chain length saturate.
  always_comb begin
    if (cap_reg == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_reg) > 32'(MAX_ENTRIES)) begin
      cap_eff = CW'(MAX_ENTRIES);
    end else begin
      cap_eff = CW'(cap_reg);
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_action <= s_tuser;
      req_key    <= s_tdata[31:0];
      req_value  <= s_tdata[63:32];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lkvc_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = lkvc_pkg::ST_COMPARE;
        end
      end
      lkvc_pkg::ST_COMPARE: begin
        state_next = lkvc_pkg::ST_UPDATE;
      end
      lkvc_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_next = lkvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkvc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Match position and stored value; at most one cell matches.
  always_comb begin
    hit_pos   = '0;
    hit_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match_vec[i]) begin
        hit_pos   = hit_pos | IW'(i);
        hit_value = hit_value | cell_entry[i].value;
      end
    end
  end

  assign hit  = |match_vec;
  assign full = (count >= cap_eff);

  // A hit rotates the matching entry to the front. A put miss pushes a new entry
  // in front; when full the entry in the last occupied position drops out.
  always_comb begin
    if (hit) begin
      limit = hit_pos;
    end else if (full) begin
      limit = IW'(count - CW'(1));
    end else begin
      limit = IW'(count);
    end
  end

  assign head = '{valid: 1'b1, key: req_key,
                  value: (req_action == lkvc_pkg::ACTION_PUT) ? req_value : hit_value};

  always_comb begin
    ctrl      = '0;
    do_update = 1'b0;
    unique case (state)
      lkvc_pkg::ST_IDLE: begin
        ctrl = '0;
      end
      lkvc_pkg::ST_COMPARE: begin
        ctrl.capture = 1'b1;
      end
      lkvc_pkg::ST_UPDATE: begin
        do_update   = out_free;
        ctrl.update = out_free && (hit || (req_action == lkvc_pkg::ACTION_PUT));
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_update && !hit && (req_action == lkvc_pkg::ACTION_PUT) && !full) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (do_update) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      m_tuser <= hit;
      if (req_action == lkvc_pkg::ACTION_PUT) begin
        m_tdata <= '0;
      end else if (hit) begin
        m_tdata <= hit_value;
      end else begin
        m_tdata <= '1;
      end
    end
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign cell_prev[g] = head;
    end else begin : g_link
      assign cell_prev[g] = cell_entry[g-1];
    end

    lkvc_cell #(
      .INDEX (g),
      .IW    (IW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .limit   (limit),
      .req_key (req_key),
      .prev    (cell_prev[g]),
      .entry   (cell_entry[g]),
      .match   (match_vec[g])
    );

    assign valid_vec[g] = cell_entry[g].valid;
  end

`ifndef SYNTHESIS
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    state == lkvc_pkg::ST_UPDATE |-> $onehot0(match_vec))
    else $error("more than one cell matched the request key");

  a_count_tracks_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(count))
    else $error("occupancy count differs from the number of valid cells");

  a_valid_packed: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec + 1'b1) & valid_vec) == '0)
    else $error("valid cells are not packed at the front of the chain");

  a_result_follows_update: assert property (@(posedge clk) disable iff (rst)
    do_update |=> m_tvalid)
    else $error("update cycle did not produce a result");
`endif

endmodule

/* dv/tb_lru_key_value_cache.sv */
// Self-checking testbench for the LRU key-value cache: directed and random gets and puts.
module tb_lru_key_value_cache;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENTRIES = 8;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = 4'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = 64'd0;   // key [31:0], value [63:32]
  logic        s_tuser = 1'b0;    // action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // read_value
  logic        m_tuser;           // hit

  lru_key_value_cache #(.MAX_ENTRIES(NUM_ENTRIES)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the cache contents and the capacity register.
  logic        ent_valid [NUM_ENTRIES];
  logic [31:0] ent_key   [NUM_ENTRIES];
  logic [31:0] ent_val   [NUM_ENTRIES];
  int unsigned ent_rank  [NUM_ENTRIES];
  int unsigned occupied = 0;
  logic [3:0]  capacity_reg = 4'd8;

  reply_t      pending_replies[$];
  logic [31:0] key_pool[$];

  int  error_count = 0;
  int  requests_sent = 0;
  int  replies_seen = 0;
  int  hits_seen = 0;
  int  evictions = 0;
  int  config_writes = 0;
  bit  source_idles = 1'b1;
  bit  sink_idles = 1'b1;
  int  stall_left = 0;

  initial begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      ent_valid[i] = 1'b0;
      ent_key[i]   = 32'd0;
      ent_val[i]   = 32'd0;
      ent_rank[i]  = 0;
    end
  end

  // Make one entry the most recent; entries that were more recent age by one.
  function automatic void promote_entry(input int slot);
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (ent_valid[i] && i != slot && ent_rank[i] < ent_rank[slot])
        ent_rank[i]++;
    ent_rank[slot] = 0;
  endfunction

  function automatic reply_t cache_access(input logic act, input logic [31:0] k,
                                          input logic [31:0] v);
    reply_t      r;
    int          slot;
    int          victim;
    int          free_slot;
    int unsigned cap;
    slot = -1;
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (slot < 0 && ent_valid[i] && ent_key[i] == k)
        slot = i;
    r.hit = (slot >= 0);
    r.read_value = 32'd0;
    if (act == lkvc_pkg::ACTION_GET) begin
      if (slot >= 0) begin
        r.read_value = ent_val[slot];
        promote_entry(slot);
      end else begin
        r.read_value = 32'hFFFF_FFFF;
      end
    end else if (slot >= 0) begin
      ent_val[slot] = v;
      promote_entry(slot);
    end else begin
      cap = capacity_reg;
      if (cap == 0) cap = 1;
      if (cap > NUM_ENTRIES) cap = NUM_ENTRIES;
      if (occupied >= cap) begin
        victim = -1;
        for (int i = 0; i < NUM_ENTRIES; i++)
          if (ent_valid[i] && (victim < 0 || ent_rank[i] > ent_rank[victim]))
            victim = i;
        if (victim >= 0) begin
          ent_valid[victim] = 1'b0;
          if (occupied > 0) occupied--;
          evictions++;
        end
      end
      free_slot = -1;
      for (int i = 0; i < NUM_ENTRIES; i++)
        if (free_slot < 0 && !ent_valid[i])
          free_slot = i;
      if (free_slot >= 0) begin
        for (int i = 0; i < NUM_ENTRIES; i++)
          if (ent_valid[i]) ent_rank[i]++;
        ent_valid[free_slot] = 1'b1;
        ent_key[free_slot]   = k;
        ent_val[free_slot]   = v;
        ent_rank[free_slot]  = 0;
        occupied++;
      end
    end
    return r;
  endfunction

  // Valid stays high between back-to-back requests; it only drops for a gap or while waiting for replies.
  task automatic send_request(input logic act, input logic [31:0] k, input logic [31:0] v);
    int gap;
    if (source_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {v, k};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_replies.push_back(cache_access(act, k, v));
    requests_sent++;
  endtask

  task automatic wait_for_replies();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [3:0] cap);
    wait_for_replies();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    capacity_reg = cap;
    config_writes++;
  endtask

  // Reply checker and downstream stall generator.
  always @(posedge clk) begin
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      replies_seen++;
      if (m_tuser) hits_seen++;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply hit=%0b read_value=%h", $time, m_tuser, m_tdata);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (m_tuser !== want.hit) begin
          $display("%0t: hit mismatch, expected %0b actual %0b", $time, want.hit, m_tuser);
          error_count++;
        end
        if (m_tdata !== want.read_value) begin
          $display("%0t: read_value mismatch, expected %h actual %h", $time,
                   want.read_value, m_tdata);
          error_count++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (sink_idles && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 15)
      return $urandom;
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  task automatic test_reset_state();
    send_request(lkvc_pkg::ACTION_GET, 32'h0000_0000, $urandom);
    send_request(lkvc_pkg::ACTION_GET, 32'hFFFF_FFFF, $urandom);
    send_request(lkvc_pkg::ACTION_PUT, 32'h0000_0005, 32'h0000_0007);
    send_request(lkvc_pkg::ACTION_GET, 32'h0000_0005, $urandom);
  endtask

  // A capacity of zero behaves as one entry.
  task automatic test_zero_capacity();
    write_capacity(4'd0);
    send_request(lkvc_pkg::ACTION_PUT, 32'h0000_0011, 32'h1234_5678);
    send_request(lkvc_pkg::ACTION_GET, 32'h0000_0005, $urandom);
    send_request(lkvc_pkg::ACTION_GET, 32'h0000_0011, $urandom);
    send_request(lkvc_pkg::ACTION_PUT, 32'h0000_0022, 32'hCAFE_F00D);
    send_request(lkvc_pkg::ACTION_GET, 32'h0000_0011, $urandom);
  endtask

  // Capacity above the entry count saturates; fill the cache and force evictions.
  task automatic test_full_cache_eviction();
    write_capacity(4'd15);
    send_request(lkvc_pkg::ACTION_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
    send_request(lkvc_pkg::ACTION_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
    send_request(lkvc_pkg::ACTION_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(lkvc_pkg::ACTION_GET, 32'h0000_0000, $urandom);
    send_request(lkvc_pkg::ACTION_GET, 32'hFFFF_FFFF, $urandom);
    for (int i = 0; i < 5; i++)
      send_request(lkvc_pkg::ACTION_PUT, 32'h0000_0100 + i, $urandom);
    send_request(lkvc_pkg::ACTION_GET, 32'h0000_0100, $urandom);
    send_request(lkvc_pkg::ACTION_PUT, 32'h0000_0106, 32'h0000_0000);
    send_request(lkvc_pkg::ACTION_GET, 32'h0000_0000, $urandom);
  endtask

  // Lowering the capacity under the occupancy evicts one entry per put miss only.
  task automatic test_shrink_below_occupancy();
    write_capacity(4'd2);
    send_request(lkvc_pkg::ACTION_PUT, 32'hDEAD_0001, 32'h0000_0001);
    send_request(lkvc_pkg::ACTION_GET, 32'hDEAD_0001, $urandom);
    send_request(lkvc_pkg::ACTION_PUT, 32'hDEAD_0002, 32'h0000_0002);
    send_request(lkvc_pkg::ACTION_GET, 32'hDEAD_0001, $urandom);
  endtask

  task automatic test_random_mix(input logic [3:0] cap, input int count, input int pool_size);
    logic [31:0] k;
    write_capacity(cap);
    key_pool.delete();
    for (int i = 0; i < pool_size; i++)
      key_pool.push_back($urandom);
    for (int i = 0; i < count; i++) begin
      k = pick_key();
      if ($urandom_range(0, 1) == 0)
        send_request(lkvc_pkg::ACTION_GET, k, $urandom);
      else
        send_request(lkvc_pkg::ACTION_PUT, k, $urandom);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_zero_capacity();
    test_random_mix(4'd1, 250, 2);
    test_random_mix(4'd3, 300, 5);
    test_random_mix(4'd5, 300, 8);
    test_full_cache_eviction();
    test_random_mix(4'd15, 350, 12);
    test_shrink_below_occupancy();
    test_random_mix(4'd2, 250, 10);
    wait_for_replies();
    source_idles = 1'b0;
    sink_idles = 1'b0;
    test_random_mix(4'd8, 450, 12);
    wait_for_replies();
    repeat (8) @(posedge clk);
    $display("Sent %0d requests and checked %0d replies, %0d of them hits.",
             requests_sent, replies_seen, hits_seen);
    $display("Saw %0d evictions across %0d capacity writes.", evictions, config_writes);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d replies outstanding.", pending_replies.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
